// File: rtl/core/met_pkg.sv
// Shared types, constants, helpers and microcode for the Mandelbrot escape-time pixel block.
package met_pkg;

	// Q4.28 fixed point
	localparam int Q_W    = 32;
	localparam int FRAC   = 28;
	// signed width of 2*index - size (index up to 10 bits, size up to 4096)
	localparam int D_W    = 14;
	localparam int STEP_W = 30;
	localparam int PROD_W = 64;
	// rounded squares reach 2^34
	localparam int SQ_W   = 35;
	// rounded cross magnitude reaches 2^35, plus sign
	localparam int XM_W   = 36;
	localparam int X_W    = 37;
	// update sums
	localparam int SUM_W  = 38;
	localparam int LEN_W  = 36;
	localparam int CNT_W  = 8;
	localparam int PC_W   = 4;

	localparam logic [LEN_W-1:0]  ESC_LIMIT = LEN_W'(4) << FRAC;
	localparam logic [PROD_W-1:0] HALF_SQ   = PROD_W'(1) << (FRAC - 1);
	localparam logic [PROD_W-1:0] HALF_X    = PROD_W'(1) << (FRAC - 2);

	// program addresses
	localparam logic [PC_W-1:0] PC_IDLE = PC_W'(0);
	localparam logic [PC_W-1:0] PC_MRE  = PC_W'(1);
	localparam logic [PC_W-1:0] PC_MIM  = PC_W'(2);
	localparam logic [PC_W-1:0] PC_INIT = PC_W'(3);
	localparam logic [PC_W-1:0] PC_SQR  = PC_W'(4);
	localparam logic [PC_W-1:0] PC_SQI  = PC_W'(5);
	localparam logic [PC_W-1:0] PC_XRI  = PC_W'(6);
	localparam logic [PC_W-1:0] PC_XRD  = PC_W'(7);
	localparam logic [PC_W-1:0] PC_UPD  = PC_W'(8);
	localparam logic [PC_W-1:0] PC_EMIT = PC_W'(9);

	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_LOOP,
		JMP_WAIT_OUT,
		JMP_GOTO
	} jmp_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_MAP_RE,
		MUL_MAP_IM,
		MUL_ZR_ZR,
		MUL_ZI_ZI,
		MUL_ZR_ZI
	} mul_sel_t;

	typedef struct packed {
		jmp_t            jmp;
		logic [PC_W-1:0] target;
		mul_sel_t        mul;
		logic            load_cre;
		logic            load_cim;
		logic            clear_z;
		logic            load_zr2;
		logic            load_zi2;
		logic            load_x;
		logic            update;
		logic            emit;
	} uword_t;

	typedef struct packed {
		logic in_fire;
		logic out_free;
		logic go_on;
	} seq_stat_t;

	function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < 64'shFFFF_FFFF_8000_0000)
			return 32'sh8000_0000;
		else
			return v[Q_W-1:0];
	endfunction

	function automatic logic [Q_W-1:0] mag32(input logic signed [Q_W-1:0] v);
		logic signed [Q_W-1:0] n;
		n = -v;
		return v[Q_W-1] ? n : v;
	endfunction

	// microcode ROM
	function automatic uword_t met_ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{jmp: JMP_NEXT, target: PC_IDLE, mul: MUL_NONE, default: 1'b0};
		unique case (pc)
			PC_IDLE: begin
				w.jmp    = JMP_WAIT_IN;
				w.target = PC_MRE;
			end
			PC_MRE: w.mul = MUL_MAP_RE;
			PC_MIM: begin
				w.load_cre = 1'b1;
				w.mul      = MUL_MAP_IM;
			end
			PC_INIT: begin
				w.load_cim = 1'b1;
				w.clear_z  = 1'b1;
			end
			PC_SQR: w.mul = MUL_ZR_ZR;
			PC_SQI: begin
				w.load_zr2 = 1'b1;
				w.mul      = MUL_ZI_ZI;
			end
			PC_XRI: begin
				w.load_zi2 = 1'b1;
				w.mul      = MUL_ZR_ZI;
			end
			PC_XRD: w.load_x = 1'b1;
			PC_UPD: begin
				w.update = 1'b1;
				w.jmp    = JMP_LOOP;
				w.target = PC_SQR;
			end
			PC_EMIT: begin
				w.emit   = 1'b1;
				w.jmp    = JMP_WAIT_OUT;
				w.target = PC_IDLE;
			end
			default: begin
				w.jmp    = JMP_GOTO;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/met_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
module met_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  met_pkg::seq_stat_t stat,
	output met_pkg::uword_t    uw
);
	import met_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic [PC_W-1:0] pc_inc;

	assign uw     = met_ucode(pc_q);
	assign pc_inc = pc_q + PC_W'(1);

	always_comb begin
		unique case (uw.jmp)
			JMP_NEXT:     pc_d = pc_inc;
			JMP_WAIT_IN:  pc_d = stat.in_fire ? uw.target : pc_q;
			JMP_LOOP:     pc_d = stat.go_on ? uw.target : pc_inc;
			JMP_WAIT_OUT: pc_d = stat.out_free ? uw.target : pc_q;
			JMP_GOTO:     pc_d = uw.target;
			default:      pc_d = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// File: rtl/core/met_dp.sv
// Datapath: coordinate mapping, shared 32x32 magnitude multiplier, z registers, counter.
module met_dp #(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480
) (
	input  logic                     clk,
	input  met_pkg::uword_t          uw,
	input  logic                     in_fire,
	input  logic [9:0]               pixel_column,
	input  logic [8:0]               pixel_row,
	input  logic [met_pkg::CNT_W-1:0] limit,
	output logic [met_pkg::CNT_W-1:0] count,
	output logic                     go_on
);
	import met_pkg::*;

	localparam logic [STEP_W-1:0] STEP_RE =
		STEP_W'(((64'd1 << 29) + 64'(IMAGE_WIDTH / 2)) / 64'(IMAGE_WIDTH));
	localparam logic [STEP_W-1:0] STEP_IM =
		STEP_W'(((64'd1 << 29) + 64'(IMAGE_HEIGHT / 2)) / 64'(IMAGE_HEIGHT));
	localparam logic signed [D_W-1:0] SIZE_RE = D_W'(IMAGE_WIDTH);
	localparam logic signed [D_W-1:0] SIZE_IM = D_W'(IMAGE_HEIGHT);

	logic signed [D_W-1:0]  d_re_q, d_im_q;
	logic signed [Q_W-1:0]  c_re_q, c_im_q, zr_q, zi_q;
	logic [SQ_W-1:0]        zr2_q, zi2_q;
	logic signed [X_W-1:0]  x_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   prod_neg_q;
	logic [CNT_W-1:0]       count_q;

	logic signed [Q_W-1:0]  op_a, op_b;
	logic [Q_W-1:0]         mag_a, mag_b;
	logic [PROD_W-1:0]      prod_d;
	logic signed [PROD_W-1:0] sprod;
	logic [PROD_W-1:0]      sq_sum, x_sum;
	logic [SQ_W-1:0]        sq_rnd;
	logic [XM_W-1:0]        x_mag;
	logic signed [X_W-1:0]  x_pos;
	logic signed [SUM_W-1:0] zi_sum, zr_sum;
	logic [LEN_W-1:0]       len;
	logic [CNT_W-1:0]       cnt_inc;

	// operand select for the shared multiplier
	always_comb begin
		unique case (uw.mul)
			MUL_MAP_RE: begin
				op_a = Q_W'(d_re_q);
				op_b = signed'(Q_W'(STEP_RE));
			end
			MUL_MAP_IM: begin
				op_a = Q_W'(d_im_q);
				op_b = signed'(Q_W'(STEP_IM));
			end
			MUL_ZR_ZR: begin
				op_a = zr_q;
				op_b = zr_q;
			end
			MUL_ZI_ZI: begin
				op_a = zi_q;
				op_b = zi_q;
			end
			MUL_ZR_ZI: begin
				op_a = zr_q;
				op_b = zi_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mag_a  = mag32(op_a);
	assign mag_b  = mag32(op_b);
	assign prod_d = mag_a * mag_b;

	// signed product for the coordinate map
	assign sprod  = prod_neg_q ? -signed'(prod_q) : signed'(prod_q);
	// round half up after dropping the fraction
	assign sq_sum = prod_q + HALF_SQ;
	assign sq_rnd = sq_sum[FRAC +: SQ_W];
	// 2*p rounded at 2^28 equals p rounded at 2^27
	assign x_sum  = prod_q + HALF_X;
	assign x_mag  = x_sum[FRAC-1 +: XM_W];
	assign x_pos  = signed'({1'b0, x_mag});

	assign zi_sum = SUM_W'(x_q) + SUM_W'(c_im_q);
	assign zr_sum = SUM_W'(signed'({1'b0, zr2_q})) - SUM_W'(signed'({1'b0, zi2_q}))
		+ SUM_W'(c_re_q);
	assign len     = {1'b0, zr2_q} + {1'b0, zi2_q};
	assign cnt_inc = count_q + CNT_W'(1);

	assign go_on = (cnt_inc < limit) && (len < ESC_LIMIT);
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			d_re_q <= signed'(D_W'({pixel_column, 1'b0})) - SIZE_RE;
			d_im_q <= signed'(D_W'({pixel_row, 1'b0})) - SIZE_IM;
		end
		if (uw.mul != MUL_NONE) begin
			prod_q     <= prod_d;
			prod_neg_q <= op_a[Q_W-1] ^ op_b[Q_W-1];
		end
		if (uw.load_cre)
			c_re_q <= sat32(sprod);
		if (uw.load_cim)
			c_im_q <= sat32(sprod);
		if (uw.load_zr2)
			zr2_q <= sq_rnd;
		if (uw.load_zi2)
			zi2_q <= sq_rnd;
		if (uw.load_x)
			x_q <= prod_neg_q ? -x_pos : x_pos;
		if (uw.clear_z) begin
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
		end else if (uw.update) begin
			zr_q    <= sat32(PROD_W'(zr_sum));
			zi_q    <= sat32(PROD_W'(zi_sum));
			count_q <= cnt_inc;
		end
	end

endmodule

// File: rtl/core/mandelbrot_escape_time_pixel_top.sv
// Top level of the Mandelbrot escape-time pixel evaluator.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+------------------------
//  cfg     | cfg_valid, cfg_ready, cfg_data[7:0]       | cfg_valid & cfg_ready
//  in      | in_valid, in_ready, pixel_column, pixel_row | in_valid & in_ready
//  out     | out_valid, out_ready, iteration_count     | out_valid & out_ready
//
// An item runs through these steps, N being its iteration count (1..max_iterations):
// one idle step, three mapping steps, five steps per iteration and one emit step.
// Five steps per iteration come from the single shared 32x32 multiplier, which
// forms zr*zr, zi*zi and zr*zi in turn, plus the rounding and update steps.
// One pixel is in flight at a time; in_ready is high only in the idle step.
// The result sits in an output register, so the next pixel is taken while it waits.
// Reset clears the step counter and the output valid and sets the limit to 255.
// cfg_ready is always high; the limit is read live, so write it only while idle.
module mandelbrot_escape_time_pixel_top #(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [9:0] pixel_column,
	input  logic [8:0] pixel_row,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] iteration_count
);
	import met_pkg::*;

	uword_t           uw;
	seq_stat_t        stat;
	logic             in_fire;
	logic             out_free;
	logic             go_on;
	logic [CNT_W-1:0] count;
	logic [CNT_W-1:0] max_iter_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] count_q;

	// input taken only while the program waits in the idle step
	assign in_ready = (uw.jmp == JMP_WAIT_IN);
	assign in_fire  = in_valid && in_ready;
	// output slot free if empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;

	assign stat = '{in_fire: in_fire, out_free: out_free, go_on: go_on};

	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign iteration_count = count_q;

	met_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uw     (uw)
	);

	met_dp #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_dp (
		.clk          (clk),
		.uw           (uw),
		.in_fire      (in_fire),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.limit        (max_iter_q),
		.count        (count),
		.go_on        (go_on)
	);

	// limit register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q  <= CNT_W'(255);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_iter_q <= cfg_data;
			if (uw.emit && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (uw.emit && out_free)
			count_q <= count;
	end

endmodule
